FILE: rtl/frm_pkg.sv
// shared types and constants of the frame rotator
package frm_pkg;

    localparam int SIZE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_ROTATION   = 2'd0;
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd2;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } frm_rot_t;

    // one classified item on its way to the frame store
    typedef struct packed {
        logic              wr;
        logic [31:0]       pixel;
        logic [15:0]       waddr;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] w;
        logic [6:0]        col;
        logic [6:0]        row;
        logic              last;
    } frm_job_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } frm_qstat_t;

endpackage

FILE: rtl/frame_rotator_90_180_270.sv
// top level of the rotating frame buffer
//
// channel   direction  transfer when          payload
// command   in         start && !busy          opcode, pixel_in
// result    out        strobe (one cycle)      pixel_out, dest_col, dest_row, last
// config    in         cfg_valid && cfg_ready  cfg_index, cfg_data
//
// one store or fetch per clock while busy is low; a fetch result passes through the job
// queue and then the registered read of the frame store
// a store is written to the frame store in the cycle after its transfer
// busy rises only when the four-entry job queue is full; the back end drains one job
// per clock, so the result side never holds anything up
// reset clears counters, read position, queue, config registers and strobe; the frame store is not cleared
module frame_rotator_90_180_270 #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int PIXEL_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] pixel_in,
    output logic        strobe,
    output logic [31:0] pixel_out,
    output logic [6:0]  dest_col,
    output logic [6:0]  dest_row,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    import frm_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    frm_rot_t          rotation_reg;
    logic [SIZE_W-1:0] src_width_reg, src_height_reg;

    logic       accept, push, pop;
    frm_job_t   push_job, head;
    frm_qstat_t q_stat;

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg   <= ROT_0;
            src_width_reg  <= SIZE_W'(128);
            src_height_reg <= SIZE_W'(128);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROTATION:   rotation_reg   <= frm_rot_t'(cfg_data[1:0]);
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    frm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (opcode),
        .pixel_in   (pixel_in),
        .rotation   (rotation_reg),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .push       (push),
        .job        (push_job)
    );

    frm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    frm_back #(
        .ADDR_W     (ADDR_W),
        .DEPTH      (DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .stat      (q_stat),
        .pop       (pop),
        .strobe    (strobe),
        .pixel_out (pixel_out),
        .dest_col  (dest_col),
        .dest_row  (dest_row),
        .last      (last)
    );

    // a result needs a fetch job that sat at the queue head in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(!q_stat.empty && !head.wr))
    else $error("result without a fetch job at the queue head");

    // the queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue overfilled");

    // the back end drains every cycle, so a push never meets a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
    else $error("job pushed into a full queue");

endmodule

FILE: rtl/frm_ram.sv
// generic single-port ram with registered read
module frm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/frm_front.sv
// front end: frame counters, read position and source coordinate mapping
module frm_front #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic                     opcode,
    input  logic [31:0]              pixel_in,
    input  frm_pkg::frm_rot_t        rotation,
    input  logic [frm_pkg::SIZE_W-1:0] src_width,
    input  logic [frm_pkg::SIZE_W-1:0] src_height,
    output logic                     push,
    output frm_pkg::frm_job_t        job
);

    import frm_pkg::*;

    logic [15:0]       write_count_reg, write_count_next;
    logic [SIZE_W-1:0] read_col_reg, read_col_next;
    logic [SIZE_W-1:0] read_row_reg, read_row_next;

    logic [SIZE_W-1:0] w, h, dw, dh, c, r, sx, sy;
    logic [15:0]       total;
    logic              full, is_last;

    always_comb
    begin
        if (src_width == '0)
            w = SIZE_W'(1);
        else if (int'(src_width) > MAX_WIDTH)
            w = SIZE_W'(MAX_WIDTH);
        else
            w = src_width;

        if (src_height == '0)
            h = SIZE_W'(1);
        else if (int'(src_height) > MAX_HEIGHT)
            h = SIZE_W'(MAX_HEIGHT);
        else
            h = src_height;

        total = {8'd0, w} * {8'd0, h};
        full  = (write_count_reg >= total);

        // quarter turns swap the destination sides
        dw = rotation[0] ? h : w;
        dh = rotation[0] ? w : h;

        if (read_col_reg >= dw || read_row_reg >= dh)
        begin
            c = '0;
            r = '0;
        end
        else
        begin
            c = read_col_reg;
            r = read_row_reg;
        end

        case (rotation)
            ROT_90:
            begin
                sx = r;
                sy = h - SIZE_W'(1) - c;
            end
            ROT_180:
            begin
                sx = w - SIZE_W'(1) - c;
                sy = h - SIZE_W'(1) - r;
            end
            ROT_270:
            begin
                sx = w - SIZE_W'(1) - r;
                sy = c;
            end
            default:
            begin
                sx = c;
                sy = r;
            end
        endcase

        is_last = (c == dw - SIZE_W'(1)) && (r == dh - SIZE_W'(1));
    end

    always_comb
    begin
        write_count_next = write_count_reg;
        read_col_next    = read_col_reg;
        read_row_next    = read_row_reg;
        push             = 1'b0;

        job.wr    = (opcode == OP_STORE);
        job.pixel = pixel_in;
        job.waddr = write_count_reg;
        job.sx    = sx;
        job.sy    = sy;
        job.w     = w;
        job.col   = c[6:0];
        job.row   = r[6:0];
        job.last  = is_last;

        if (accept)
        begin
            if (opcode == OP_STORE)
            begin
                push = 1'b1;
                if (full)
                begin
                    // new frame starts at the first entry
                    job.waddr        = '0;
                    write_count_next = 16'd1;
                    read_col_next    = '0;
                    read_row_next    = '0;
                end
                else
                begin
                    write_count_next = write_count_reg + 16'd1;
                end
            end
            else if (full)
            begin
                push = 1'b1;
                if (c + SIZE_W'(1) < dw)
                begin
                    read_col_next = c + SIZE_W'(1);
                    read_row_next = r;
                end
                else
                begin
                    read_col_next = '0;
                    read_row_next = (r + SIZE_W'(1) < dh) ? r + SIZE_W'(1) : '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_count_reg <= '0;
            read_col_reg    <= '0;
            read_row_reg    <= '0;
        end
        else
        begin
            write_count_reg <= write_count_next;
            read_col_reg    <= read_col_next;
            read_row_reg    <= read_row_next;
        end
    end

endmodule

FILE: rtl/frm_queue.sv
// short job queue between front end and back end
module frm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  frm_pkg::frm_job_t   push_job,
    input  logic                pop,
    output frm_pkg::frm_job_t   head,
    output frm_pkg::frm_qstat_t stat
);

    import frm_pkg::*;

    frm_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    always_comb
    begin
        stat.empty = (count_reg == '0);
        stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
        stat.count = count_reg;
        head       = entry_reg[rd_ptr_reg];

        do_push = push && !stat.full;
        do_pop  = pop && !stat.empty;

        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;

        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/frm_back.sv
// back end: address generation, frame store access and result register
module frm_back #(
    parameter int ADDR_W     = 14,
    parameter int DEPTH      = 16384,
    parameter int PIXEL_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  frm_pkg::frm_job_t   head,
    input  frm_pkg::frm_qstat_t stat,
    output logic                pop,
    output logic                strobe,
    output logic [31:0]         pixel_out,
    output logic [6:0]          dest_col,
    output logic [6:0]          dest_row,
    output logic                last
);

    import frm_pkg::*;

    logic [16:0]           raster_addr;
    logic [ADDR_W-1:0]     addr;
    logic                  we, re;
    logic [PIXEL_BITS-1:0] rdata;

    logic                  strobe_reg, strobe_next;
    logic [6:0]            col_reg, row_reg;
    logic                  last_reg;

    always_comb
    begin
        pop         = !stat.empty;
        raster_addr = {9'd0, head.sy} * {9'd0, head.w} + {9'd0, head.sx};
        addr        = head.wr ? ADDR_W'(head.waddr) : ADDR_W'(raster_addr);
        we          = pop && head.wr;
        re          = pop && !head.wr;
        strobe_next = re;
    end

    frm_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .re    (re),
        .addr  (addr),
        .wdata (head.pixel[PIXEL_BITS-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            col_reg  <= head.col;
            row_reg  <= head.row;
            last_reg <= head.last;
        end
    end

    assign strobe    = strobe_reg;
    assign pixel_out = 32'(rdata);
    assign dest_col  = col_reg;
    assign dest_row  = row_reg;
    assign last      = last_reg;

endmodule

FILE: tb/tb_frame_rotator_90_180_270.sv
// testbench for the rotating frame buffer: directed corner cases, then random frames
`timescale 1ns / 100ps

module tb_frame_rotator_90_180_270;

    import frm_pkg::*;

    localparam int unsigned MAX_DIM     = 128;
    localparam int unsigned FRAME_DEPTH = MAX_DIM * MAX_DIM;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned SETTLE      = 8;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [31:0] pixel;
        logic [6:0]  col;
        logic [6:0]  row;
        logic        last;
    } rot_pixel_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    logic        opcode    = OP_STORE;
    logic [31:0] pixel_in  = '0;
    logic        strobe;
    logic [31:0] pixel_out;
    logic [6:0]  dest_col;
    logic [6:0]  dest_row;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ROTATION;
    logic [7:0]  cfg_data  = '0;

    // predictor state
    logic [31:0]  src_pixels [FRAME_DEPTH];
    int unsigned  pixels_stored;
    int unsigned  next_row;
    int unsigned  next_col;
    frm_rot_t     rot_setting;
    logic [7:0]   width_setting;
    logic [7:0]   height_setting;

    rot_pixel_t   pending_pixels [$];
    int unsigned  error_count  = 0;
    int unsigned  useful_items = 0;
    int unsigned  cycle_count  = 0;
    int unsigned  sender_idle_pct = 0;

    frame_rotator_90_180_270 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .pixel_in  (pixel_in),
        .strobe    (strobe),
        .pixel_out (pixel_out),
        .dest_col  (dest_col),
        .dest_row  (dest_row),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [7:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return 32'(v);
    endfunction

    // advance the frame predictor by one item; returns 1 when a pixel comes out
    function automatic bit rotate_step(input logic op, input logic [31:0] pix,
                                       output rot_pixel_t res);
        int unsigned w, h, total, dw, dh, sx, sy, c, r;
        w     = clamp_dim(width_setting);
        h     = clamp_dim(height_setting);
        total = w * h;
        res   = '0;
        if (op == OP_STORE)
        begin
            if (pixels_stored >= total)
            begin
                pixels_stored = 0;
                next_row      = 0;
                next_col      = 0;
            end
            src_pixels[pixels_stored % FRAME_DEPTH] = pix;
            pixels_stored++;
            return 1'b0;
        end
        if (pixels_stored < total)
            return 1'b0;
        if (rot_setting == ROT_90 || rot_setting == ROT_270)
        begin
            dw = h;
            dh = w;
        end
        else
        begin
            dw = w;
            dh = h;
        end
        // position left outside the frame by a size or rotation change
        if (next_col >= dw || next_row >= dh)
        begin
            next_col = 0;
            next_row = 0;
        end
        c = next_col;
        r = next_row;
        case (rot_setting)
            ROT_90:
            begin
                sx = r;
                sy = h - 1 - c;
            end
            ROT_180:
            begin
                sx = w - 1 - c;
                sy = h - 1 - r;
            end
            ROT_270:
            begin
                sx = w - 1 - r;
                sy = c;
            end
            default:
            begin
                sx = c;
                sy = r;
            end
        endcase
        res.pixel = src_pixels[(sy * w + sx) % FRAME_DEPTH];
        res.col   = c[6:0];
        res.row   = r[6:0];
        res.last  = (c == dw - 1) && (r == dh - 1);
        if (c + 1 < dw)
            next_col = c + 1;
        else
        begin
            next_col = 0;
            next_row = (r + 1 < dh) ? r + 1 : 0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    // tracks transfers on all three channels and checks every result pixel
    always @(posedge clk)
    begin : frame_monitor
        rot_pixel_t want;
        if (!rst_n)
        begin
            pixels_stored  = 0;
            next_row       = 0;
            next_col       = 0;
            rot_setting    = ROT_0;
            width_setting  = 8'd128;
            height_setting = 8'd128;
        end
        else
        begin
            if (strobe)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("unexpected pixel", pixel_out, '0);
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_out !== want.pixel)
                        report_mismatch("pixel_out", pixel_out, want.pixel);
                    if (dest_col !== want.col)
                        report_mismatch("dest_col", 32'(dest_col), 32'(want.col));
                    if (dest_row !== want.row)
                        report_mismatch("dest_row", 32'(dest_row), 32'(want.row));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROTATION:   rot_setting    = frm_rot_t'(cfg_data[1:0]);
                    CFG_SRC_WIDTH:  width_setting  = cfg_data;
                    CFG_SRC_HEIGHT: height_setting = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (rotate_step(opcode, pixel_in, want))
                begin
                    pending_pixels.push_back(want);
                    useful_items++;
                end
                else if (opcode == OP_STORE)
                    useful_items++;
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels outstanding",
                 cycle_count, pending_pixels.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_item(input logic op, input logic [31:0] pix);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        pixel_in <= pix;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic wait_drained;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // registers change only once the block has gone quiet
    task automatic configure(input frm_rot_t rot, input logic [7:0] w, input logic [7:0] h);
        logic [5:0] junk;
        junk = 6'($urandom);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_ROTATION, {junk, rot});
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_fetch_before_full;
        send_item(OP_FETCH, $urandom);
        send_item(OP_FETCH, $urandom);
        send_item(OP_STORE, 32'h0000_0000);
        send_item(OP_STORE, 32'hFFFF_FFFF);
        send_item(OP_FETCH, $urandom);
    endtask

    // two pixels already held make a 1x2 frame full
    task automatic test_shrunk_frame;
        configure(ROT_0, 8'd1, 8'd2);
        repeat (3) send_item(OP_FETCH, $urandom);
    endtask

    task automatic test_read_restart;
        configure(ROT_90, 8'd1, 8'd2);
        repeat (2) send_item(OP_FETCH, $urandom);
    endtask

    task automatic test_store_on_full;
        send_item(OP_STORE, $urandom);
        send_item(OP_FETCH, $urandom);
        send_item(OP_STORE, $urandom);
        repeat (2) send_item(OP_FETCH, $urandom);
    endtask

    task automatic test_spare_register;
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        write_reg(CFG_SPARE, 8'($urandom));
        cfg_valid <= 1'b0;
        send_item(OP_FETCH, $urandom);
    endtask

    task automatic test_random_frames;
        int unsigned phase, w, h, total, n_store, n_fetch, i;
        int unsigned idle_modes [3];
        logic [7:0]  w_cfg, h_cfg;
        frm_rot_t    rot;
        bit          rot_only;
        idle_modes = '{0, 83, 38};
        phase = 0;
        w_cfg = 8'd4;
        h_cfg = 8'd3;
        while (useful_items < ITEM_TARGET)
        begin
            sender_idle_pct = idle_modes[phase % 3];
            rot_only = 1'b0;
            case (phase)
                0: begin w_cfg = 8'd255; h_cfg = 8'd0;   end
                1: begin w_cfg = 8'd0;   h_cfg = 8'd255; end
                2: begin w_cfg = 8'd128; h_cfg = 8'd1;   end
                3: begin w_cfg = 8'd1;   h_cfg = 8'd128; end
                default:
                begin
                    if ($urandom_range(99) < 20)
                        rot_only = 1'b1;
                    else if ($urandom_range(99) < 4)
                    begin
                        w_cfg = 8'd128;
                        h_cfg = 8'($urandom_range(1, 2));
                        if ($urandom_range(1))
                        begin
                            h_cfg = w_cfg;
                            w_cfg = 8'($urandom_range(1, 2));
                        end
                    end
                    else
                    begin
                        w_cfg = 8'($urandom_range(0, 6));
                        h_cfg = 8'($urandom_range(0, 6));
                    end
                end
            endcase
            rot   = (phase < 4) ? frm_rot_t'(2'(phase)) : frm_rot_t'(2'($urandom_range(3)));
            w     = clamp_dim(w_cfg);
            h     = clamp_dim(h_cfg);
            total = w * h;
            configure(rot, w_cfg, h_cfg);

            // a rotation change alone re-reads the frame already held
            if (!rot_only)
            begin
                n_store = total;
                if ($urandom_range(99) < 10)
                    n_store = $urandom_range(0, total - 1);
                for (i = 0; i < n_store; i++)
                begin
                    if ($urandom_range(99) < 8)
                        send_item(OP_FETCH, $urandom);
                    send_item(OP_STORE, $urandom);
                end
            end

            n_fetch = total + ((total > 16) ? $urandom_range(0, 8) : $urandom_range(0, total + 2));
            for (i = 0; i < n_fetch; i++)
            begin
                if ($urandom_range(99) < 3)
                    send_item(OP_STORE, $urandom);
                else
                    send_item(OP_FETCH, $urandom);
                if ($urandom_range(99) < 2)
                    wait_drained();
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fetch_before_full();
        test_shrunk_frame();
        test_read_restart();
        test_store_on_full();
        test_spare_register();
        test_random_frames();

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: frame_rotator_90_180_270.f
rtl/frm_pkg.sv
rtl/frm_ram.sv
rtl/frm_front.sv
rtl/frm_queue.sv
rtl/frm_back.sv
rtl/frame_rotator_90_180_270.sv
tb/tb_frame_rotator_90_180_270.sv
